// ===== hdl/size_class_slab_allocator_defines.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SCSA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SCSA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/scsa_pkg.sv =====
// Shared types and constants of the size-class slab allocator.
// Depends on nothing; imported by the top level, the checker and the testbench.
package scsa_pkg;

    localparam int ADDR_W  = 18;
    localparam int SIZE_W  = 16;
    localparam int BYTES_W = 19;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    localparam int IN_TDATA_W  = ((SIZE_W + ADDR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ADDR_W + 2 * BYTES_W + 7) / 8) * 8;

    localparam int DEF_MIN_CHUNK   = 16;
    localparam int DEF_CLASS_COUNT = 8;
    localparam int DEF_PAGE_BYTES  = 4096;
    localparam int DEF_POOL_PAGES  = 64;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_CLASS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;

endpackage

// ===== hdl/scsa_class_mem.sv =====
// Per-class table: freed-chunk stack top and carve state of each class.
// Synchronous memory with registered read data and per-entry valid bits for
// reset and release. Depends on nothing.
module scsa_class_mem #(
    parameter int CLS_W   = 3,
    parameter int ENTRY_W = 38
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [CLS_W-1:0]   rd_addr,
    output logic [ENTRY_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [CLS_W-1:0]   wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               clear_all
);

    localparam int DEPTH = 1 << CLS_W;

    logic [ENTRY_W-1:0] entry_ram [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (clear_all) begin
            valid_next = '0;
        end else if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_ram[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= entry_ram[rd_addr];
        end
    end

    // an entry never written since reset or release reads as all zeros
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/scsa_link_mem.sv =====
// Link memory of the freed-chunk stacks: one entry per minimum chunk.
// Simple dual-port synchronous RAM, read data registered. Depends on nothing.
module scsa_link_mem #(
    parameter int IDX_W  = 14,
    parameter int DATA_W = 15
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    localparam int DEPTH = 1 << IDX_W;

    logic [DATA_W-1:0] link_ram [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_ram[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= link_ram[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/size_class_slab_allocator.sv =====
// Slab allocator over a fixed arena of pages with power-of-two size classes;
// uses scsa_pkg, scsa_class_mem, scsa_link_mem and the assertion header.
// One item at a time: free, release-all, no-op, an oversize request and an
// alloc carved from a page pass a class table read, then the result step with
// any write-back; an alloc that pops a freed chunk adds a link memory read
// between the two, at the stack top that the class table returns. A result that is not taken
// holds the block in its last state. Reset and release-all clear the class
// table through valid bits at once, so there is no clearing pass; link
// entries are written before any read reaches them.
`include "size_class_slab_allocator_defines.svh"

module size_class_slab_allocator
    import scsa_pkg::*;
#(
    parameter int MIN_CHUNK   = DEF_MIN_CHUNK,
    parameter int CLASS_COUNT = DEF_CLASS_COUNT,
    parameter int PAGE_BYTES  = DEF_PAGE_BYTES,
    parameter int POOL_PAGES  = DEF_POOL_PAGES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // request_size, chunk_address, zero fill
    input  logic [OP_W-1:0]        s_tuser,  // opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // granted_address, mapped_bytes, used_bytes
    output logic [STAT_W-1:0]      m_tuser   // status
);

    localparam int MIN_LG  = $clog2(MIN_CHUNK);
    localparam int PAGE_LG = $clog2(PAGE_BYTES);
    localparam int IDX_W   = ADDR_W - MIN_LG;
    localparam int CLS_W   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int LEFT_W  = $clog2(PAGE_BYTES / MIN_CHUNK + 1);
    localparam int PG_W    = $clog2(POOL_PAGES + 1);
    localparam int SUM_W   = PG_W + CLASS_COUNT + 1;
    localparam int CHUNK_W = MIN_LG + CLASS_COUNT;
    localparam int WIDE_W  = ((CHUNK_W > BYTES_W) ? CHUNK_W : BYTES_W) + 1;
    localparam int MB_W    = PG_W + PAGE_LG + BYTES_W;
    localparam int LINK_W  = 1 + IDX_W;
    localparam int ENTRY_W = LINK_W + IDX_W + LEFT_W;
    localparam int SHIFT_W = 32;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CLS  = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    // input item fields
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] chunk_addr;
    logic              accept;
    logic [CLS_W-1:0]  in_cls;
    logic              in_oversize;

    // held item
    logic [OP_W-1:0]   op_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic              oversize_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    // control and counters
    logic [1:0]         state_reg, state_next;
    logic [PG_W-1:0]    pages_reg, pages_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;
    logic               done;

    // result payload
    logic [STAT_W-1:0]  stat_reg;
    logic [ADDR_W-1:0]  gaddr_reg;
    logic [BYTES_W-1:0] mapped_reg;
    logic [BYTES_W-1:0] used_reg;
    logic [STAT_W-1:0]  res_stat;
    logic [ADDR_W-1:0]  res_addr;

    // memory ports
    logic [ENTRY_W-1:0] cls_rd_data;
    logic               cls_wr_en;
    logic [ENTRY_W-1:0] cls_wr_data;
    logic               cls_clear;
    logic               link_rd_en;
    logic [LINK_W-1:0]  link_rd_data;
    logic               link_wr_en;

    // class entry fields
    logic               top_v;
    logic [IDX_W-1:0]   top_idx;
    logic [IDX_W-1:0]   carve_next;
    logic [LEFT_W-1:0]  carve_left;

    // alloc and free arithmetic
    logic [CHUNK_W-1:0] chunk_bytes;
    logic [LEFT_W-1:0]  per_page;
    logic [SUM_W-1:0]   grant_pages;
    logic [SUM_W-1:0]   pages_sum;
    logic               need_grant;
    logic               exhausted;
    logic [IDX_W-1:0]   base_idx;
    logic [IDX_W-1:0]   carve_idx;
    logic [IDX_W-1:0]   carve_next_new;
    logic [LEFT_W-1:0]  carve_left_new;
    logic [WIDE_W-1:0]  bytes_sum;
    logic [BYTES_W-1:0] bytes_add;
    logic [BYTES_W-1:0] bytes_sub;

    assign req_size   = s_tdata[SIZE_W-1:0];
    assign chunk_addr = s_tdata[SIZE_W +: ADDR_W];
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;

    // smallest class that fits; scan downward so the smallest match wins
    always_comb begin
        in_cls = CLS_W'(CLASS_COUNT - 1);
        for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
            if (SHIFT_W'(req_size) <= (SHIFT_W'(MIN_CHUNK) << i)) begin
                in_cls = CLS_W'(i);
            end
        end
        in_oversize = SHIFT_W'(req_size) > (SHIFT_W'(MIN_CHUNK) << (CLASS_COUNT - 1));
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= s_tuser;
            cls_reg      <= in_cls;
            oversize_reg <= in_oversize;
            free_idx_reg <= chunk_addr[ADDR_W-1:MIN_LG];
        end
    end

    scsa_class_mem #(
        .CLS_W   (CLS_W),
        .ENTRY_W (ENTRY_W)
    ) u_class_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr   (in_cls),
        .rd_data   (cls_rd_data),
        .wr_en     (cls_wr_en),
        .wr_addr   (cls_reg),
        .wr_data   (cls_wr_data),
        .clear_all (cls_clear)
    );

    scsa_link_mem #(
        .IDX_W  (IDX_W),
        .DATA_W (LINK_W)
    ) u_link_mem (
        .aclk    (aclk),
        .rd_en   (link_rd_en),
        .rd_addr (top_idx),
        .rd_data (link_rd_data),
        .wr_en   (link_wr_en),
        .wr_addr (free_idx_reg),
        .wr_data ({top_v, top_idx})
    );

    assign {top_v, top_idx, carve_next, carve_left} = cls_rd_data;

    // grant geometry of the held class
    always_comb begin
        chunk_bytes = CHUNK_W'(MIN_CHUNK) << cls_reg;
        if (int'(cls_reg) <= PAGE_LG - MIN_LG) begin
            per_page = LEFT_W'(1) << (PAGE_LG - MIN_LG - int'(cls_reg));
        end else begin
            per_page = LEFT_W'(1);
        end
        if (MIN_LG + int'(cls_reg) > PAGE_LG) begin
            grant_pages = SUM_W'(1) << (MIN_LG + int'(cls_reg) - PAGE_LG);
        end else begin
            grant_pages = SUM_W'(1);
        end
    end

    assign need_grant     = (carve_left == '0);
    assign pages_sum      = SUM_W'(pages_reg) + grant_pages;
    assign exhausted      = need_grant && (pages_sum > SUM_W'(POOL_PAGES));
    assign base_idx       = IDX_W'((ADDR_W + PG_W)'(pages_reg) << (PAGE_LG - MIN_LG));
    assign carve_idx      = need_grant ? base_idx : carve_next;
    assign carve_next_new = carve_idx + (IDX_W'(1) << cls_reg);
    assign carve_left_new = (need_grant ? per_page : carve_left) - LEFT_W'(1);

    // used total saturates upward and floors at zero downward
    assign bytes_sum = WIDE_W'(bytes_reg) + WIDE_W'(chunk_bytes);
    assign bytes_add = (bytes_sum > WIDE_W'({BYTES_W{1'b1}})) ? {BYTES_W{1'b1}}
                                                              : BYTES_W'(bytes_sum);
    assign bytes_sub = (WIDE_W'(bytes_reg) > WIDE_W'(chunk_bytes))
                     ? BYTES_W'(WIDE_W'(bytes_reg) - WIDE_W'(chunk_bytes)) : '0;

    always_comb begin
        state_next  = state_reg;
        done        = 1'b0;
        cls_wr_en   = 1'b0;
        cls_wr_data = cls_rd_data;
        cls_clear   = 1'b0;
        link_rd_en  = 1'b0;
        link_wr_en  = 1'b0;
        pages_next  = pages_reg;
        bytes_next  = bytes_reg;
        res_stat    = ST_OK;
        res_addr    = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_CLS;
                end
            end
            S_CLS: begin
                if (op_reg == OP_ALLOC && !oversize_reg && top_v) begin
                    // pop: fetch the entry below the stack top
                    link_rd_en = 1'b1;
                    state_next = S_LINK;
                end else if (out_free) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_ALLOC: begin
                            if (oversize_reg) begin
                                res_stat = ST_NO_CLASS;
                            end else if (exhausted) begin
                                res_stat = ST_EXHAUSTED;
                            end else begin
                                cls_wr_en   = 1'b1;
                                cls_wr_data = {top_v, top_idx, carve_next_new, carve_left_new};
                                if (need_grant) begin
                                    pages_next = PG_W'(pages_sum);
                                end
                                bytes_next = bytes_add;
                                res_addr   = {carve_idx, {MIN_LG{1'b0}}};
                            end
                        end
                        OP_FREE: begin
                            if (oversize_reg) begin
                                res_stat = ST_NO_CLASS;
                            end else begin
                                link_wr_en  = 1'b1;
                                cls_wr_en   = 1'b1;
                                cls_wr_data = {1'b1, free_idx_reg, carve_next, carve_left};
                                bytes_next  = bytes_sub;
                            end
                        end
                        OP_RELEASE: begin
                            cls_clear  = 1'b1;
                            pages_next = '0;
                            bytes_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LINK: begin
                if (out_free) begin
                    done        = 1'b1;
                    state_next  = S_IDLE;
                    cls_wr_en   = 1'b1;
                    cls_wr_data = {link_rd_data, carve_next, carve_left};
                    bytes_next  = bytes_add;
                    res_addr    = {top_idx, {MIN_LG{1'b0}}};
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid_next = done || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pages_reg   <= '0;
            bytes_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pages_reg   <= pages_next;
            bytes_reg   <= bytes_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            stat_reg   <= res_stat;
            gaddr_reg  <= res_addr;
            mapped_reg <= BYTES_W'(MB_W'(pages_next) << PAGE_LG);
            used_reg   <= bytes_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({used_reg, mapped_reg, gaddr_reg});
    assign m_tuser  = stat_reg;

    `SCSA_ASSERT_IMP(a_pages_bound, aclk, aresetn, 1'b1, pages_reg <= PG_W'(POOL_PAGES), "page count beyond pool")
    `SCSA_ASSERT_IMP(a_err_no_addr, aclk, aresetn, m_valid_reg && stat_reg != ST_OK, gaddr_reg == '0, "address on failed item")
    `SCSA_ASSERT_NXT(a_accept_reads, aclk, aresetn, accept, state_reg == S_CLS, "accepted item skipped table read")
    `SCSA_ASSERT_NXT(a_release_clr, aclk, aresetn, done && op_reg == OP_RELEASE, pages_reg == '0 && bytes_reg == '0, "release left totals")

endmodule

// ===== tb/scsa_checker.sv =====
// Result checker for the size-class slab allocator: watches both item channels,
// predicts every result from its own copy of the allocator state and compares.
// Depends on scsa_pkg; instantiated by tb_size_class_slab_allocator.
module scsa_checker
    import scsa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]        s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic [STAT_W-1:0]      m_tuser,
    output int                     fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINK_DEPTH = (1 << ADDR_W) / DEF_MIN_CHUNK;
    localparam int IDX_W      = $clog2(LINK_DEPTH);
    localparam int BYTES_MAX  = (1 << BYTES_W) - 1;
    localparam int MAX_CHUNK  = DEF_MIN_CHUNK << (DEF_CLASS_COUNT - 1);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ADDR_W-1:0]  granted;
        logic [BYTES_W-1:0] mapped;
        logic [BYTES_W-1:0] used;
    } alloc_result_t;

    // Stack tops and links carry a valid bit above the chunk index.
    logic [IDX_W:0] stack_top [DEF_CLASS_COUNT];
    logic [IDX_W:0] link_mem  [LINK_DEPTH];
    int             carve_idx   [DEF_CLASS_COUNT];
    int             carve_count [DEF_CLASS_COUNT];
    int             page_count;
    int             live_bytes;

    alloc_result_t  expected_results [$];
    int             errors  = 0;
    int             pending = 0;

    assign fail_count = errors + pending;

    function automatic int class_for_size(logic [SIZE_W-1:0] req_size);
        int cls;
        int span;
        cls  = 0;
        span = DEF_MIN_CHUNK;
        if (req_size > MAX_CHUNK)
            return -1;
        while (req_size > span && cls < DEF_CLASS_COUNT - 1) begin
            span = span << 1;
            cls++;
        end
        return cls;
    endfunction

    function automatic void clear_allocator();
        for (int c = 0; c < DEF_CLASS_COUNT; c++) begin
            stack_top[c]   = '0;
            carve_idx[c]   = 0;
            carve_count[c] = 0;
        end
        page_count = 0;
        live_bytes = 0;
    endfunction

    function automatic alloc_result_t apply_alloc_op(logic [OP_W-1:0]   op,
                                                     logic [SIZE_W-1:0] req_size,
                                                     logic [ADDR_W-1:0] chunk_addr);
        alloc_result_t r;
        int cls;
        int chunk_bytes;
        int idx;
        int per_grant;
        int grant_pages;
        r.status  = ST_OK;
        r.granted = '0;
        if (op == OP_RELEASE) begin
            clear_allocator();
        end else if (op != OP_NOP) begin
            cls = class_for_size(req_size);
            if (cls < 0) begin
                r.status = ST_NO_CLASS;
            end else begin
                chunk_bytes = DEF_MIN_CHUNK << cls;
                if (op == OP_FREE) begin
                    idx = int'(chunk_addr) / DEF_MIN_CHUNK;
                    link_mem[idx]  = stack_top[cls];
                    stack_top[cls] = {1'b1, IDX_W'(idx)};
                    live_bytes = (live_bytes > chunk_bytes) ? live_bytes - chunk_bytes : 0;
                end else if (stack_top[cls][IDX_W]) begin
                    idx = int'(stack_top[cls][IDX_W-1:0]);
                    stack_top[cls] = link_mem[idx];
                    r.granted = ADDR_W'(idx * DEF_MIN_CHUNK);
                end else begin
                    if (carve_count[cls] == 0) begin
                        per_grant   = (DEF_PAGE_BYTES + chunk_bytes - 1) / chunk_bytes;
                        grant_pages = (per_grant * chunk_bytes + DEF_PAGE_BYTES - 1)
                                      / DEF_PAGE_BYTES;
                        if (page_count + grant_pages > DEF_POOL_PAGES) begin
                            r.status = ST_EXHAUSTED;
                        end else begin
                            carve_idx[cls]   = page_count * DEF_PAGE_BYTES / DEF_MIN_CHUNK;
                            carve_count[cls] = per_grant;
                            page_count      += grant_pages;
                        end
                    end
                    if (r.status == ST_OK) begin
                        r.granted = ADDR_W'(carve_idx[cls] * DEF_MIN_CHUNK);
                        carve_idx[cls]   += chunk_bytes / DEF_MIN_CHUNK;
                        carve_count[cls] -= 1;
                    end
                end
                if (op == OP_ALLOC && r.status == ST_OK)
                    live_bytes = (live_bytes + chunk_bytes > BYTES_MAX) ?
                                 BYTES_MAX : live_bytes + chunk_bytes;
            end
        end
        r.mapped = BYTES_W'(page_count * DEF_PAGE_BYTES);
        r.used   = BYTES_W'(live_bytes);
        return r;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        alloc_result_t want;
        if (!aresetn) begin
            clear_allocator();
            expected_results.delete();
        end else begin
            // Compare first: a result never belongs to the item taken at the same edge.
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("granted_address", want.granted, m_tdata[ADDR_W-1:0]);
                    check_field("mapped_bytes", want.mapped,
                                m_tdata[ADDR_W+BYTES_W-1:ADDR_W]);
                    check_field("used_bytes", want.used,
                                m_tdata[ADDR_W+2*BYTES_W-1:ADDR_W+BYTES_W]);
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_alloc_op(s_tuser, s_tdata[SIZE_W-1:0],
                                                          s_tdata[SIZE_W+ADDR_W-1:SIZE_W]));
        end
        pending = expected_results.size();
    end

endmodule

// ===== tb/tb_size_class_slab_allocator.sv =====
// Top of the slab allocator testbench: clock, reset, directed and random items,
// idle bursts on both channels and the verdict.
// Depends on scsa_pkg, size_class_slab_allocator and scsa_checker.
module tb_size_class_slab_allocator
    import scsa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHUNK  = DEF_MIN_CHUNK << (DEF_CLASS_COUNT - 1);
    localparam int LONG_HOLD  = 300;
    localparam int FILL_ITEMS = 140;
    localparam int SAT_ITEMS  = 265;
    localparam int RAND_ITEMS = 320;
    localparam int CALM_ITEMS = 100;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] req_size;
    } issued_item_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] req_size;
    } live_chunk_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [OP_W-1:0]        s_tuser  = OP_NOP;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]      m_tuser;
    int                     fail_count;

    issued_item_t in_flight [$];
    live_chunk_t  live_chunks [$];
    bit           sender_idles = 1'b1;
    bit           sink_idles   = 1'b1;
    bit           hold_results = 1'b0;

    size_class_slab_allocator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    scsa_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count)
    );

    always #10 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Track items in flight and the chunks currently handed out, for well-formed frees.
    always @(posedge aclk) begin
        issued_item_t done;
        if (aresetn) begin
            if (m_tvalid && m_tready && in_flight.size() != 0) begin
                done = in_flight.pop_front();
                if (done.op == OP_RELEASE)
                    live_chunks.delete();
                else if (done.op == OP_ALLOC && m_tuser == ST_OK)
                    live_chunks.push_back('{m_tdata[ADDR_W-1:0], done.req_size});
            end
            if (s_tvalid && s_tready)
                in_flight.push_back('{s_tuser, s_tdata[SIZE_W-1:0]});
        end
    end

    // Result side: random stall bursts, plus one long hold when asked.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_results = 1'b0;
            end else if (sink_idles && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0]   op,
                             input logic [SIZE_W-1:0] req_size,
                             input logic [ADDR_W-1:0] chunk_addr);
        if (sender_idles && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_TDATA_W'({chunk_addr, req_size});
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [SIZE_W-1:0] draw_size();
        int cls;
        int top_size;
        if ($urandom_range(0, 9) == 0)
            return SIZE_W'($urandom_range(MAX_CHUNK + 1, 65535));
        cls      = $urandom_range(0, DEF_CLASS_COUNT - 1);
        top_size = DEF_MIN_CHUNK << cls;
        return SIZE_W'($urandom_range(cls == 0 ? 0 : top_size / 2 + 1, top_size));
    endfunction

    task automatic draw_random_item(output logic [OP_W-1:0]   op,
                                    output logic [SIZE_W-1:0] req_size,
                                    output logic [ADDR_W-1:0] chunk_addr);
        int roll;
        int pick;
        roll       = $urandom_range(0, 99);
        req_size   = SIZE_W'($urandom);
        chunk_addr = ADDR_W'($urandom);
        if (roll < 2) begin
            op = OP_RELEASE;
        end else if (roll < 5) begin
            op = OP_NOP;
        end else if (roll < 65) begin
            op       = OP_ALLOC;
            req_size = draw_size();
        end else begin
            op = OP_FREE;
            if (live_chunks.size() != 0 && $urandom_range(0, 3) != 0) begin
                pick       = $urandom_range(0, live_chunks.size() - 1);
                req_size   = live_chunks[pick].req_size;
                chunk_addr = live_chunks[pick].addr;
                // Drop a few low bits in now and then; the block must ignore them.
                if ($urandom_range(0, 7) == 0)
                    chunk_addr = chunk_addr | ADDR_W'($urandom_range(1, DEF_MIN_CHUNK - 1));
                live_chunks.delete(pick);
            end else begin
                req_size = draw_size();
            end
        end
    endtask

    initial begin
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] chunk_addr;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Class boundaries, oversize, unaligned and mismatched frees, no-op, release.
        send_item(OP_ALLOC, 0, 0);
        send_item(OP_ALLOC, 16, 0);
        send_item(OP_ALLOC, 17, 0);
        send_item(OP_ALLOC, 32, 0);
        send_item(OP_ALLOC, 33, 0);
        send_item(OP_ALLOC, 1024, 0);
        send_item(OP_ALLOC, 1025, 0);
        send_item(OP_ALLOC, 2048, 0);
        send_item(OP_ALLOC, 2049, 0);
        send_item(OP_ALLOC, 16'hFFFF, 18'h3FFFF);
        send_item(OP_FREE, 2048, 18'd18432 + 18'd7);
        send_item(OP_ALLOC, 1500, 0);
        send_item(OP_FREE, 16'hFFFF, 18'h3FFFF);
        send_item(OP_FREE, 16, 18'h3FFFF);
        send_item(OP_FREE, 2048, 0);
        send_item(OP_NOP, 16'hFFFF, 18'h3FFFF);
        send_item(OP_ALLOC, 1, 0);
        send_item(OP_ALLOC, 2048, 0);
        send_item(OP_ALLOC, 65, 0);
        send_item(OP_ALLOC, 256, 0);
        send_item(OP_ALLOC, 512, 0);
        send_item(OP_ALLOC, 513, 0);
        send_item(OP_RELEASE, 16'hFFFF, 18'h3FFFF);
        send_item(OP_ALLOC, 0, 0);

        // Mostly large allocs until the arena runs out of pages.
        send_item(OP_RELEASE, 0, 0);
        for (int i = 0; i < FILL_ITEMS; i++) begin
            if ($urandom_range(0, 7) == 0)
                req_size = SIZE_W'($urandom_range(0, 1024));
            else
                req_size = SIZE_W'($urandom_range(1025, MAX_CHUNK));
            send_item(OP_ALLOC, req_size, ADDR_W'($urandom));
        end
        send_item(OP_RELEASE, 0, 0);

        // Free one chunk twice so its stack links to itself, then pop it until
        // the used total saturates.
        chunk_addr = ADDR_W'($urandom_range(0, 127) * MAX_CHUNK);
        send_item(OP_FREE, MAX_CHUNK, chunk_addr);
        send_item(OP_FREE, MAX_CHUNK, chunk_addr);
        for (int i = 0; i < SAT_ITEMS; i++)
            send_item(OP_ALLOC, SIZE_W'($urandom_range(1025, MAX_CHUNK)), 0);
        send_item(OP_RELEASE, 0, 0);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            sender_idles = (i < RAND_ITEMS - CALM_ITEMS) && ((i / 40) % 3 != 2);
            sink_idles   = (i < RAND_ITEMS - CALM_ITEMS) && ((i / 50) % 3 != 1);
            if (i == 80)
                hold_results = 1'b1;
            if (i == 160) begin
                s_tvalid <= 1'b0;
                // Step past the accepting edge so the last item is counted in flight.
                do @(posedge aclk); while (in_flight.size() != 0);
            end
            draw_random_item(op, req_size, chunk_addr);
            send_item(op, req_size, chunk_addr);
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (in_flight.size() != 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/scsa_pkg.sv
hdl/scsa_class_mem.sv
hdl/scsa_link_mem.sv
hdl/size_class_slab_allocator.sv
tb/scsa_checker.sv
tb/tb_size_class_slab_allocator.sv
